// File: rtl/prd_pkg.sv
package prd_pkg;

  // Port widths and rotation length
  localparam int COORD_WIDTH    = 24;
  localparam int ANGLE_WIDTH    = 32;
  localparam int ROT_ITERATIONS = 20;

  // Datapath: guard bits below the coordinate LSB, headroom for negate and gain
  localparam int GUARD_BITS = 8;
  localparam int DW         = COORD_WIDTH + GUARD_BITS + 3;
  localparam int GV_W       = DW + 1;
  localparam int ZW         = 33;            // residual angle, 2^-24 degree
  localparam int Z_SHIFT    = 16;            // 1/256 degree -> 2^-24 degree

  // Angle reduction: 92160 = 2^11 * 45, and 2^12 = 1 (mod 45)
  localparam int LO_BITS     = 11;
  localparam int QW          = ANGLE_WIDTH - LO_BITS;
  localparam int CHUNK       = 12;
  localparam int NCH         = (QW + CHUNK - 1) / CHUNK;
  localparam int SUMW        = $clog2(NCH * 4095 + 1);
  localparam int TURN_MOD    = 45;
  localparam int RECIP       = 11651;        // ceil(2^19 / 45)
  localparam int RECIP_W     = 14;
  localparam int RECIP_SHIFT = 19;
  localparam int PW          = SUMW + RECIP_W;
  localparam int Q45W        = SUMW - 5;
  localparam int REM_W       = 6;
  localparam int R_W         = REM_W + LO_BITS;
  localparam int RS_W        = R_W + 1;

  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;

  // Gain multiply, split in two partial products
  localparam int GAIN_W = 30;
  localparam int ML     = DW / 2;
  localparam int MH     = DW - ML;
  localparam int PLW    = ML + GAIN_W;
  localparam int PHW    = MH + GAIN_W;
  localparam int SW     = DW + GAIN_W + 1;

  localparam longint unsigned RAD2DEG_Q26 = 64'd3845054675;

  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] val;
    logic                          clip;
  } sat_t;

  // 2^n mod 45, for the bias added to the folded quotient
  function automatic int unsigned pow2_mod45(input int unsigned n);
    int unsigned m;
    m = 1;
    for (int unsigned i = 0; i < n; i++) begin
      m = m * 2;
      if (m >= TURN_MOD) m = m - TURN_MOD;
    end
    return m;
  endfunction

  // Restoring long division for the series terms
  function automatic longint unsigned udiv64(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  localparam int BIAS_MOD = int'(pow2_mod45(QW - 1));

  // atan(2^-i) in 2^-24 degree: series in Q62 radians, scaled and rounded
  function automatic logic [ZW-1:0] atan_entry(input int unsigned i);
    longint unsigned r;
    longint unsigned term;
    longint unsigned prod;
    int unsigned s;
    int unsigned odd;
    r = 0;
    if (i == 0) return ZW'(64'd45 << 24);
    for (int unsigned k = 0; k < 32; k++) begin
      odd = 2 * k + 1;
      s   = i * odd;
      if (s <= 62) begin
        term = udiv64(64'd1 << (62 - s), 64'(odd));
        if (k[0]) r = r - term;
        else r = r + term;
      end
    end
    prod = (r >> 30) * RAD2DEG_Q26 + (64'd1 << 33);
    return ZW'(prod >> 34);
  endfunction

  // Largest Q30 g with ((g*g)>>30)*P>>30 <= 2^30, P the truncated gain product
  function automatic logic [GAIN_W-1:0] gain_q30();
    longint unsigned p;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    p  = 64'd1 << 30;
    lo = 0;
    hi = 64'd1 << 30;
    for (int unsigned i = 0; i < ROT_ITERATIONS && i < 32; i++) begin
      p = p + (p >> (2 * i));
    end
    for (int n = 0; n < 40; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (((((mid * mid) >> 30) * p) >> 30) <= (64'd1 << 30)) lo = mid;
        else hi = mid - 1;
      end
    end
    return GAIN_W'(lo);
  endfunction

  localparam logic [GAIN_W-1:0] GAIN_Q30 = gain_q30();

endpackage

// File: rtl/point_rotate_2d_degrees.sv
// Channel  Signals                              Direction  Transfer when
// in       in_valid in_ready x/y_coord angle    input      in_valid && in_ready
// out      out_valid out_ready rot_x/y clipped  output     out_valid && out_ready
//
// Pipeline of ROT_ITERATIONS + 8 register stages (28 at the default length):
// four for angle reduction, one per CORDIC micro-rotation, four for gain and
// saturation. One point per cycle unless a held result stalls the pipe.
// Each stage loads whenever it or any stage after it holds a bubble, so a held
// result stalls only the full stages behind it. Reset clears the valid bits.
module point_rotate_2d_degrees (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [prd_pkg::COORD_WIDTH-1:0]  x_coord,
  input  logic signed [prd_pkg::COORD_WIDTH-1:0]  y_coord,
  input  logic signed [prd_pkg::ANGLE_WIDTH-1:0]  angle_deg,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [prd_pkg::COORD_WIDTH-1:0]  rot_x,
  output logic signed [prd_pkg::COORD_WIDTH-1:0]  rot_y,
  output logic                                    clipped
);

  localparam int N      = prd_pkg::ROT_ITERATIONS;
  localparam int CW     = prd_pkg::COORD_WIDTH;
  localparam int DW     = prd_pkg::DW;
  localparam int ZW     = prd_pkg::ZW;
  localparam int GV_W   = prd_pkg::GV_W;
  localparam int NST    = N + 8;
  localparam int S_SUM  = 0;
  localparam int S_QUO  = 1;
  localparam int S_REM  = 2;
  localparam int S_FOLD = 3;
  localparam int S_ROT0 = 4;
  localparam int S_MAG  = N + 4;
  localparam int S_PROD = N + 5;
  localparam int S_GAIN = N + 6;
  localparam int S_OUT  = N + 7;

  localparam logic signed [GV_W-1:0] HALF_LSB = GV_W'(1) <<< (prd_pkg::GUARD_BITS - 1);
  localparam logic signed [GV_W-1:0] MAX_EXT  = GV_W'(prd_pkg::COORD_MAX);
  localparam logic signed [GV_W-1:0] MIN_EXT  = GV_W'(prd_pkg::COORD_MIN);

  // Round off the guard bits and clamp to the coordinate range
  function automatic prd_pkg::sat_t finish(input logic signed [GV_W-1:0] v);
    logic signed [GV_W-1:0] r;
    prd_pkg::sat_t          s;
    r = (v + HALF_LSB) >>> prd_pkg::GUARD_BITS;
    s.clip = 1'b0;
    s.val  = CW'(r);
    if (r > MAX_EXT) begin
      s.val  = prd_pkg::COORD_MAX;
      s.clip = 1'b1;
    end else if (r < MIN_EXT) begin
      s.val  = prd_pkg::COORD_MIN;
      s.clip = 1'b1;
    end
    return s;
  endfunction

  // ---------------------------------------------------------------- control
  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic [NST-1:0] vld_in;

  // stage k loads when a bubble sits at k or anywhere downstream
  always_comb begin
    logic [NST-1:0] upper;
    for (int k = 0; k < NST; k++) begin
      upper = (vld >> k) | ~({NST{1'b1}} >> k);
      en[k] = out_ready || (upper != {NST{1'b1}});
    end
  end

  assign vld_in    = {vld[NST-2:0], in_valid};
  assign in_ready  = en[S_SUM];
  assign out_valid = vld[S_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  // ------------------------------------------------ stage 0: fold quotient
  // angle = q*2048 + lo; bias q to unsigned, sum its 12-bit chunks (mod 45)
  logic [prd_pkg::QW-1:0]                   qb;
  logic [prd_pkg::NCH*prd_pkg::CHUNK-1:0]   qpad;
  logic [prd_pkg::SUMW-1:0]                 csum;
  logic [prd_pkg::SUMW-1:0]                 s0_sum;
  logic [prd_pkg::LO_BITS-1:0]              s0_lo;
  logic signed [CW-1:0]                     s0_x;
  logic signed [CW-1:0]                     s0_y;

  assign qb   = {~angle_deg[prd_pkg::ANGLE_WIDTH-1],
                 angle_deg[prd_pkg::ANGLE_WIDTH-2:prd_pkg::LO_BITS]};
  assign qpad = (prd_pkg::NCH * prd_pkg::CHUNK)'(qb);

  always_comb begin
    csum = '0;
    for (int j = 0; j < prd_pkg::NCH; j++) begin
      csum = csum + prd_pkg::SUMW'(qpad[j*prd_pkg::CHUNK +: prd_pkg::CHUNK]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      s0_sum <= csum;
      s0_lo  <= angle_deg[prd_pkg::LO_BITS-1:0];
      s0_x   <= x_coord;
      s0_y   <= y_coord;
    end
  end

  // ------------------------------------------ stage 1: quotient by 45
  logic [prd_pkg::PW-1:0]    qprod;
  logic [prd_pkg::Q45W-1:0]  s1_q;
  logic [prd_pkg::SUMW-1:0]  s1_sum;
  logic [prd_pkg::LO_BITS-1:0] s1_lo;
  logic signed [CW-1:0]      s1_x;
  logic signed [CW-1:0]      s1_y;

  assign qprod = prd_pkg::PW'(s0_sum) * prd_pkg::PW'(prd_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (en[S_QUO]) begin
      s1_q   <= qprod[prd_pkg::PW-1:prd_pkg::RECIP_SHIFT];
      s1_sum <= s0_sum;
      s1_lo  <= s0_lo;
      s1_x   <= s0_x;
      s1_y   <= s0_y;
    end
  end

  // -------------------------------------- stage 2: remainder, remove bias
  logic [prd_pkg::SUMW-1:0]  rem_full;
  logic [prd_pkg::REM_W-1:0] rem6;
  logic [prd_pkg::REM_W-1:0] rem_adj;
  logic [prd_pkg::REM_W-1:0] s2_rem;
  logic [prd_pkg::LO_BITS-1:0] s2_lo;
  logic signed [CW-1:0]      s2_x;
  logic signed [CW-1:0]      s2_y;

  assign rem_full = s1_sum - prd_pkg::SUMW'(prd_pkg::SUMW'(s1_q) *
                                            prd_pkg::SUMW'(prd_pkg::TURN_MOD));
  assign rem6     = rem_full[prd_pkg::REM_W-1:0];

  always_comb begin
    if (rem6 >= prd_pkg::REM_W'(prd_pkg::BIAS_MOD)) begin
      rem_adj = rem6 - prd_pkg::REM_W'(prd_pkg::BIAS_MOD);
    end else begin
      rem_adj = rem6 + prd_pkg::REM_W'(prd_pkg::TURN_MOD - prd_pkg::BIAS_MOD);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_REM]) begin
      s2_rem <= rem_adj;
      s2_lo  <= s1_lo;
      s2_x   <= s1_x;
      s2_y   <= s1_y;
    end
  end

  // --------------------------- stage 3: fold into [-90, 90], scale to Q24
  logic [prd_pkg::R_W-1:0]          r_red;
  logic signed [prd_pkg::RS_W-1:0]  r_pos;
  logic signed [prd_pkg::RS_W-1:0]  r_fold;
  logic                             flip;
  logic signed [DW-1:0]             xe;
  logic signed [DW-1:0]             ye;

  logic signed [DW-1:0] cx [0:N];
  logic signed [DW-1:0] cy [0:N];
  logic signed [ZW-1:0] cz [0:N-1];

  assign r_red = {s2_rem, s2_lo};
  assign r_pos = signed'({1'b0, r_red});
  assign xe    = DW'(s2_x) <<< prd_pkg::GUARD_BITS;
  assign ye    = DW'(s2_y) <<< prd_pkg::GUARD_BITS;

  always_comb begin
    flip   = 1'b0;
    r_fold = r_pos;
    if (r_red > prd_pkg::R_W'(prd_pkg::QUARTER_TURN) &&
        r_red < prd_pkg::R_W'(prd_pkg::FULL_TURN - prd_pkg::QUARTER_TURN)) begin
      flip   = 1'b1;
      r_fold = r_pos - prd_pkg::RS_W'(prd_pkg::HALF_TURN);
    end else if (r_red >= prd_pkg::R_W'(prd_pkg::FULL_TURN - prd_pkg::QUARTER_TURN)) begin
      r_fold = r_pos - prd_pkg::RS_W'(prd_pkg::FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_FOLD]) begin
      cx[0] <= flip ? -xe : xe;
      cy[0] <= flip ? -ye : ye;
      cz[0] <= ZW'(r_fold) <<< prd_pkg::Z_SHIFT;
    end
  end

  // ------------------------------------------- CORDIC micro-rotations
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN_I = prd_pkg::atan_entry(i);

    always_ff @(posedge clk) begin
      if (en[S_ROT0+i]) begin
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
        end
      end
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (en[S_ROT0+i]) begin
          cz[i+1] <= cz[i][ZW-1] ? cz[i] + ATAN_I : cz[i] - ATAN_I;
        end
      end
    end
  end

  // ------------------------------------------------ gain: magnitude
  logic [DW-1:0] gm_x;
  logic [DW-1:0] gm_y;
  logic          gs_x;
  logic          gs_y;

  always_ff @(posedge clk) begin
    if (en[S_MAG]) begin
      gm_x <= cx[N][DW-1] ? DW'(-cx[N]) : DW'(cx[N]);
      gm_y <= cy[N][DW-1] ? DW'(-cy[N]) : DW'(cy[N]);
      gs_x <= cx[N][DW-1];
      gs_y <= cy[N][DW-1];
    end
  end

  // ------------------------------------------ gain: partial products
  logic [prd_pkg::PLW-1:0] pl_x;
  logic [prd_pkg::PLW-1:0] pl_y;
  logic [prd_pkg::PHW-1:0] ph_x;
  logic [prd_pkg::PHW-1:0] ph_y;
  logic                    ps_x;
  logic                    ps_y;

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      pl_x <= prd_pkg::PLW'(gm_x[prd_pkg::ML-1:0]) * prd_pkg::PLW'(prd_pkg::GAIN_Q30);
      pl_y <= prd_pkg::PLW'(gm_y[prd_pkg::ML-1:0]) * prd_pkg::PLW'(prd_pkg::GAIN_Q30);
      ph_x <= prd_pkg::PHW'(gm_x[DW-1:prd_pkg::ML]) * prd_pkg::PHW'(prd_pkg::GAIN_Q30);
      ph_y <= prd_pkg::PHW'(gm_y[DW-1:prd_pkg::ML]) * prd_pkg::PHW'(prd_pkg::GAIN_Q30);
      ps_x <= gs_x;
      ps_y <= gs_y;
    end
  end

  // --------------------------------- gain: combine, round, restore sign
  logic [prd_pkg::SW-1:0] tot_x;
  logic [prd_pkg::SW-1:0] tot_y;
  logic signed [GV_W-1:0] mag_x;
  logic signed [GV_W-1:0] mag_y;
  logic signed [GV_W-1:0] gv_x;
  logic signed [GV_W-1:0] gv_y;

  assign tot_x = (prd_pkg::SW'(ph_x) << prd_pkg::ML) + prd_pkg::SW'(pl_x) +
                 (prd_pkg::SW'(1) << (prd_pkg::GAIN_W - 1));
  assign tot_y = (prd_pkg::SW'(ph_y) << prd_pkg::ML) + prd_pkg::SW'(pl_y) +
                 (prd_pkg::SW'(1) << (prd_pkg::GAIN_W - 1));
  assign mag_x = signed'(tot_x[prd_pkg::SW-1:prd_pkg::GAIN_W]);
  assign mag_y = signed'(tot_y[prd_pkg::SW-1:prd_pkg::GAIN_W]);

  always_ff @(posedge clk) begin
    if (en[S_GAIN]) begin
      gv_x <= ps_x ? -mag_x : mag_x;
      gv_y <= ps_y ? -mag_y : mag_y;
    end
  end

  // -------------------------------------- output register: round, clamp
  prd_pkg::sat_t fx;
  prd_pkg::sat_t fy;

  assign fx = finish(gv_x);
  assign fy = finish(gv_y);

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      rot_x   <= fx.val;
      rot_y   <= fy.val;
      clipped <= fx.clip | fy.clip;
    end
  end

endmodule

// File: rtl/prd_checker.sv
module prd_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [prd_pkg::COORD_WIDTH-1:0] rot_x,
  input logic signed [prd_pkg::COORD_WIDTH-1:0] rot_y,
  input logic                                   clipped
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input back-pressure only when the pipe is full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a held result");

  // a clipped result sits at a range limit
  a_clip_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |->
      (rot_x == prd_pkg::COORD_MAX || rot_x == prd_pkg::COORD_MIN ||
       rot_y == prd_pkg::COORD_MAX || rot_y == prd_pkg::COORD_MIN))
    else $error("clipped set with no coordinate at a limit");

  // held result stays put until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(rot_x) && $stable(rot_y) && $stable(clipped)))
    else $error("held result changed before transfer");

endmodule

bind point_rotate_2d_degrees prd_checker u_prd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rot_x     (rot_x),
  .rot_y     (rot_y),
  .clipped   (clipped)
);
